// ===== sv/vsfb_pkg.sv =====
// Package for the voxel solid-fraction binner.
// Holds shared types, command and register codes and sizing constants.
// No dependencies.
package vsfb_pkg;

  localparam int RES_X_DEF = 32;
  localparam int RES_Y_DEF = 32;
  localparam int RES_Z_DEF = 32;

  localparam int IDX_W      = 15;
  localparam int STORE_DEPTH = 32768;
  localparam int FRAC_W     = 15;
  localparam int CRD_W      = 8;
  localparam int DATA_W     = 32;
  localparam int APB_AW     = 5;
  localparam int VEL_W      = 3 * DATA_W;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 15'd31130;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_DEPOSIT = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_INV_LEN_X = 3'd3,
    REG_INV_LEN_Y = 3'd4,
    REG_INV_LEN_Z = 3'd5,
    REG_FRAC_SCALE = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [4:0] {
    ST_WIPE,
    ST_IDLE,
    ST_CLEAR,
    ST_DIFF,
    ST_ABS,
    ST_MUL,
    ST_CHK,
    ST_IX0,
    ST_IX1,
    ST_IX2,
    ST_D0,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_LOAD,
    ST_RD,
    ST_USE
  } state_t;

endpackage

// ===== sv/voxel_solid_fraction_binner.sv =====
// Top level of the voxel solid-fraction binner: sequencer, config registers,
// fraction and velocity stores. Depends on vsfb_pkg, vsfb_mul and vsfb_ram.
//
// One command is taken when start is high and busy is low; busy stays high
// until its result is registered. The result is shown for exactly one cycle
// with out_valid high and must be captured then; the next command can be
// taken in that same cycle. All multiplications run through one 32x32
// multiplier stepped by the sequencer, one product per cycle. A clear writes
// the 32768-entry fraction store one entry per cycle; the same pass runs after
// reset, and busy stays high for that pass. Configuration writes are taken at
// any time.
module voxel_solid_fraction_binner
  import vsfb_pkg::*;
#(
  parameter int RES_X = RES_X_DEF,
  parameter int RES_Y = RES_Y_DEF,
  parameter int RES_Z = RES_Z_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_cmd,
  input  logic signed [31:0]       in_pos_x,
  input  logic signed [31:0]       in_pos_y,
  input  logic signed [31:0]       in_pos_z,
  input  logic [15:0]              in_diameter,
  input  logic [IDX_W-1:0]         in_load_index,
  input  logic signed [31:0]       in_load_vel_x,
  input  logic signed [31:0]       in_load_vel_y,
  input  logic signed [31:0]       in_load_vel_z,
  output logic                     out_valid,
  output logic [FRAC_W-1:0]        out_fraction,
  output logic signed [31:0]       out_vel_x_out,
  output logic signed [31:0]       out_vel_y_out,
  output logic signed [31:0]       out_vel_z_out,
  output logic [IDX_W-1:0]         out_voxel_at,
  output logic                     out_outside,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam logic [DATA_W-1:0] RX_C   = DATA_W'(RES_X);
  localparam logic [DATA_W-1:0] RXY_C  = DATA_W'(RES_X * RES_Y);
  localparam logic [24:0]       TOTAL  = 25'(RES_X * RES_Y * RES_Z);
  localparam logic [8:0]        RES_X9 = 9'(RES_X);
  localparam logic [8:0]        RES_Y9 = 9'(RES_Y);
  localparam logic [8:0]        RES_Z9 = 9'(RES_Z);
  localparam logic [IDX_W-1:0]  CLR_LAST = IDX_W'(STORE_DEPTH - 1);

  // configuration registers
  logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic [31:0]        inv_len_x_r, inv_len_y_r, inv_len_z_r, frac_scale_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // sequencer and item registers
  state_t             state_r, state_nxt;
  cmd_t               cmd_r;
  axis_t              ax_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [15:0]        dia_r;
  logic [IDX_W-1:0]   li_r;
  logic signed [31:0] lvx_r, lvy_r, lvz_r;
  logic [32:0]        diff_r, mag_r;
  logic               neg_r;
  logic [CRD_W-1:0]   cx_r, cy_r, cz_r;
  logic [IDX_W-1:0]   idx_r, addr_r, clr_r;
  logic [47:0]        d3_r;
  logic [63:0]        acc_r;
  logic [FRAC_W-1:0]  add_r;
  logic               sat_r;

  // result registers
  logic               out_valid_r, out_valid_nxt;
  logic [FRAC_W-1:0]  out_fraction_r, out_fraction_nxt;
  logic [31:0]        out_vx_r, out_vx_nxt, out_vy_r, out_vy_nxt, out_vz_r, out_vz_nxt;
  logic [IDX_W-1:0]   out_voxel_r, out_voxel_nxt;
  logic               out_outside_r, out_outside_nxt;

  // shared multiplier
  logic [DATA_W-1:0]   mul_a, mul_b;
  logic [2*DATA_W-1:0] mul_p;

  // stores
  logic               frac_we;
  logic [IDX_W-1:0]   frac_waddr;
  logic [FRAC_W-1:0]  frac_wdata, frac_rdata;
  logic               vel_we;
  logic [VEL_W-1:0]   vel_wdata, vel_rdata;

  // axis and check logic
  logic signed [31:0] sel_pos, sel_org;
  logic [31:0]        sel_inv;
  logic [8:0]         sel_res;
  logic [32:0]        hi33;
  logic               prod_nz, in_grid;
  logic [CRD_W-1:0]   coord;
  logic [48:0]        dep_hi;
  logic [40:0]        dep_amt;
  logic [15:0]        frac_sum;
  logic [FRAC_W-1:0]  frac_new;
  logic               li_bad;
  logic               accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      origin_z_r   <= '0;
      inv_len_x_r  <= 32'd65536;
      inv_len_y_r  <= 32'd65536;
      inv_len_z_r  <= 32'd65536;
      frac_scale_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORIGIN_X:   origin_x_r   <= pwdata;
        REG_ORIGIN_Y:   origin_y_r   <= pwdata;
        REG_ORIGIN_Z:   origin_z_r   <= pwdata;
        REG_INV_LEN_X:  inv_len_x_r  <= pwdata;
        REG_INV_LEN_Y:  inv_len_y_r  <= pwdata;
        REG_INV_LEN_Z:  inv_len_z_r  <= pwdata;
        REG_FRAC_SCALE: frac_scale_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORIGIN_X:   prdata = origin_x_r;
      REG_ORIGIN_Y:   prdata = origin_y_r;
      REG_ORIGIN_Z:   prdata = origin_z_r;
      REG_INV_LEN_X:  prdata = inv_len_x_r;
      REG_INV_LEN_Y:  prdata = inv_len_y_r;
      REG_INV_LEN_Z:  prdata = inv_len_z_r;
      REG_FRAC_SCALE: prdata = frac_scale_r;
      default:        prdata = '0;
    endcase
  end

  // axis select
  always_comb begin
    unique case (ax_r)
      AX_X: begin
        sel_pos = pos_x_r; sel_org = origin_x_r; sel_inv = inv_len_x_r; sel_res = RES_X9;
      end
      AX_Y: begin
        sel_pos = pos_y_r; sel_org = origin_y_r; sel_inv = inv_len_y_r; sel_res = RES_Y9;
      end
      default: begin
        sel_pos = pos_z_r; sel_org = origin_z_r; sel_inv = inv_len_z_r; sel_res = RES_Z9;
      end
    endcase
  end

  // bin check on the product
  always_comb begin
    hi33    = mag_r[32] ? {1'b0, sel_inv} : {1'b0, mul_p[63:32]};
    prod_nz = mag_r[32] ? (sel_inv != '0) : (mul_p != '0);
    in_grid = neg_r ? !prod_nz : (hi33 < {24'd0, sel_res});
    coord   = neg_r ? '0 : hi33[CRD_W-1:0];
  end

  // deposit amount: (d^3 * scale) >> 40 from two partial products
  assign dep_hi  = {1'b0, mul_p[47:0]} + {17'd0, acc_r[63:32]};
  assign dep_amt = dep_hi[48:8];

  assign frac_sum = {1'b0, frac_rdata} + {1'b0, add_r};
  assign frac_new = (sat_r || (frac_sum > {1'b0, FRAC_MAX})) ? FRAC_MAX : frac_sum[FRAC_W-1:0];
  assign li_bad   = ({10'd0, li_r} >= TOTAL);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_WIPE:  if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_t'(in_cmd))
            CMD_CLEAR: state_nxt = ST_CLEAR;
            CMD_LOAD:  state_nxt = ST_LOAD;
            default:   state_nxt = ST_DIFF;
          endcase
        end
      end
      ST_CLEAR: if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_DIFF:  state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CHK;
      ST_CHK: begin
        if (!in_grid)        state_nxt = ST_IDLE;
        else if (ax_r == AX_Z) state_nxt = ST_IX0;
        else                 state_nxt = ST_DIFF;
      end
      ST_IX0:   state_nxt = ST_IX1;
      ST_IX1:   state_nxt = ST_IX2;
      ST_IX2:   state_nxt = (cmd_r == CMD_DEPOSIT) ? ST_D0 : ST_RD;
      ST_D0:    state_nxt = ST_D1;
      ST_D1:    state_nxt = ST_D2;
      ST_D2:    state_nxt = ST_D3;
      ST_D3:    state_nxt = ST_D4;
      ST_D4:    state_nxt = ST_RD;
      ST_LOAD:  state_nxt = li_bad ? ST_IDLE : ST_RD;
      ST_RD:    state_nxt = ST_USE;
      ST_USE:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    frac_we          = 1'b0;
    frac_waddr       = addr_r;
    frac_wdata       = frac_new;
    vel_we           = 1'b0;
    vel_wdata        = {lvz_r, lvy_r, lvx_r};
    out_valid_nxt    = 1'b0;
    out_fraction_nxt = '0;
    out_vx_nxt       = '0;
    out_vy_nxt       = '0;
    out_vz_nxt       = '0;
    out_voxel_nxt    = '0;
    out_outside_nxt  = 1'b0;
    unique case (state_r)
      ST_WIPE: begin
        frac_we    = 1'b1;
        frac_waddr = clr_r;
        frac_wdata = '0;
      end
      ST_CLEAR: begin
        frac_we       = 1'b1;
        frac_waddr    = clr_r;
        frac_wdata    = '0;
        out_valid_nxt = (clr_r == CLR_LAST);
      end
      ST_MUL: begin
        mul_a = mag_r[31:0];
        mul_b = sel_inv;
      end
      ST_CHK: begin
        out_valid_nxt   = !in_grid;
        out_outside_nxt = 1'b1;
      end
      ST_IX0: begin
        mul_a = {{(DATA_W-CRD_W){1'b0}}, cz_r};
        mul_b = RXY_C;
      end
      ST_IX1: begin
        mul_a = {{(DATA_W-CRD_W){1'b0}}, cy_r};
        mul_b = RX_C;
      end
      ST_D0: begin
        mul_a = {16'd0, dia_r};
        mul_b = {16'd0, dia_r};
      end
      ST_D1: begin
        mul_a = mul_p[31:0];
        mul_b = {16'd0, dia_r};
      end
      ST_D2: begin
        mul_a = mul_p[31:0];
        mul_b = frac_scale_r;
      end
      ST_D3: begin
        mul_a = {16'd0, d3_r[47:32]};
        mul_b = frac_scale_r;
      end
      ST_LOAD: begin
        vel_we          = !li_bad;
        out_valid_nxt   = li_bad;
        out_voxel_nxt   = li_r;
        out_outside_nxt = 1'b1;
      end
      ST_USE: begin
        frac_we          = (cmd_r == CMD_DEPOSIT);
        out_valid_nxt    = 1'b1;
        out_fraction_nxt = (cmd_r == CMD_DEPOSIT) ? frac_new : frac_rdata;
        out_vx_nxt       = (cmd_r == CMD_LOAD) ? lvx_r : vel_rdata[31:0];
        out_vy_nxt       = (cmd_r == CMD_LOAD) ? lvy_r : vel_rdata[63:32];
        out_vz_nxt       = (cmd_r == CMD_LOAD) ? lvz_r : vel_rdata[95:64];
        out_voxel_nxt    = addr_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_WIPE || state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_cmd);
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      dia_r   <= in_diameter;
      li_r    <= in_load_index;
      lvx_r   <= in_load_vel_x;
      lvy_r   <= in_load_vel_y;
      lvz_r   <= in_load_vel_z;
      ax_r    <= AX_X;
    end
    case (state_r)
      ST_DIFF: diff_r <= {sel_pos[31], sel_pos} - {sel_org[31], sel_org};
      ST_ABS: begin
        mag_r <= diff_r[32] ? (33'd0 - diff_r) : diff_r;
        neg_r <= diff_r[32];
      end
      ST_CHK: begin
        case (ax_r)
          AX_X:    cx_r <= coord;
          AX_Y:    cy_r <= coord;
          default: cz_r <= coord;
        endcase
        if (ax_r == AX_X) ax_r <= AX_Y;
        else              ax_r <= AX_Z;
      end
      ST_IX1:  idx_r  <= mul_p[IDX_W-1:0];
      ST_IX2:  addr_r <= idx_r + mul_p[IDX_W-1:0] + {{(IDX_W-CRD_W){1'b0}}, cx_r};
      ST_D2:   d3_r   <= mul_p[47:0];
      ST_D3:   acc_r  <= mul_p;
      ST_D4: begin
        add_r <= dep_amt[FRAC_W-1:0];
        sat_r <= (dep_amt > {26'd0, FRAC_MAX});
      end
      ST_LOAD: addr_r <= li_r;
      default: ;
    endcase
    if (out_valid_nxt) begin
      out_fraction_r <= out_fraction_nxt;
      out_vx_r       <= out_vx_nxt;
      out_vy_r       <= out_vy_nxt;
      out_vz_r       <= out_vz_nxt;
      out_voxel_r    <= out_voxel_nxt;
      out_outside_r  <= out_outside_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_fraction  = out_fraction_r;
  assign out_vel_x_out = out_vx_r;
  assign out_vel_y_out = out_vy_r;
  assign out_vel_z_out = out_vz_r;
  assign out_voxel_at  = out_voxel_r;
  assign out_outside   = out_outside_r;

  vsfb_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vsfb_ram #(
    .WIDTH (FRAC_W),
    .DEPTH (STORE_DEPTH)
  ) u_frac_ram (
    .clk   (clk),
    .we    (frac_we),
    .waddr (frac_waddr),
    .wdata (frac_wdata),
    .raddr (addr_r),
    .rdata (frac_rdata)
  );

  vsfb_ram #(
    .WIDTH (VEL_W),
    .DEPTH (STORE_DEPTH)
  ) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (li_r),
    .wdata (vel_wdata),
    .raddr (addr_r),
    .rdata (vel_rdata)
  );

endmodule

// ===== sv/vsfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Parameters set width and depth; no package dependency.
module vsfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/vsfb_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on vsfb_pkg for the operand width.
module vsfb_mul
  import vsfb_pkg::*;
(
  input  logic                  clk,
  input  logic [DATA_W-1:0]     a,
  input  logic [DATA_W-1:0]     b,
  output logic [2*DATA_W-1:0]   p
);

  logic [2*DATA_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign p = prod_r;

endmodule

// ===== verif/vsfb_checker.sv =====
// Checker for the voxel solid-fraction binner: tracks the grid registers and voxel
// stores, predicts one result per accepted command, compares each result strobe and
// checks register readback. Depends on vsfb_pkg.
module vsfb_checker
  import vsfb_pkg::*;
#(
  parameter int RES_X = RES_X_DEF,
  parameter int RES_Y = RES_Y_DEF,
  parameter int RES_Z = RES_Z_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           in_cmd,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic [15:0]          in_diameter,
  input  logic [IDX_W-1:0]     in_load_index,
  input  logic signed [31:0]   in_load_vel_x,
  input  logic signed [31:0]   in_load_vel_y,
  input  logic signed [31:0]   in_load_vel_z,
  input  logic                 out_valid,
  input  logic [FRAC_W-1:0]    out_fraction,
  input  logic signed [31:0]   out_vel_x_out,
  input  logic signed [31:0]   out_vel_y_out,
  input  logic signed [31:0]   out_vel_z_out,
  input  logic [IDX_W-1:0]     out_voxel_at,
  input  logic                 out_outside,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  input  logic [DATA_W-1:0]    prdata,
  input  logic                 pready,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic [31:0]       vel_x;
    logic [31:0]       vel_y;
    logic [31:0]       vel_z;
    logic [IDX_W-1:0]  voxel_at;
    logic              outside;
  } voxel_report_t;

  logic signed [31:0] origin [3];
  logic [31:0]        inv_len [3];
  logic [31:0]        frac_scale;
  logic [15:0]        frac_mem [STORE_DEPTH];
  logic [31:0]        vel_mem_x [STORE_DEPTH];
  logic [31:0]        vel_mem_y [STORE_DEPTH];
  logic [31:0]        vel_mem_z [STORE_DEPTH];
  bit                 vel_loaded [STORE_DEPTH];
  voxel_report_t      awaited [$];

  function automatic bit bin_axis(input logic signed [31:0] pos, input logic signed [31:0] org,
                                  input logic [31:0] inv, input int res, output int coord);
    longint     diff;
    logic [63:0] mag;
    logic [63:0] prod;
    diff = longint'(pos) - longint'(org);
    mag = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, inv};
    coord = 0;
    if (diff < 0) return prod == 0;
    if ((prod >> 32) >= 64'(res)) return 1'b0;
    coord = int'(prod >> 32);
    return 1'b1;
  endfunction

  function automatic bit find_voxel(input logic signed [31:0] px, input logic signed [31:0] py,
                                    input logic signed [31:0] pz, output logic [IDX_W-1:0] at);
    int cx, cy, cz;
    logic [31:0] lin;
    at = '0;
    if (!bin_axis(px, origin[AX_X], inv_len[AX_X], RES_X, cx)) return 1'b0;
    if (!bin_axis(py, origin[AX_Y], inv_len[AX_Y], RES_Y, cy)) return 1'b0;
    if (!bin_axis(pz, origin[AX_Z], inv_len[AX_Z], RES_Z, cz)) return 1'b0;
    lin = cz * RES_X * RES_Y + cy * RES_X + cx;
    at = lin[IDX_W-1:0];
    return 1'b1;
  endfunction

  // The stimulus side asks this before a deposit or query, so no unloaded velocity is read.
  function automatic bit needs_velocity(input logic signed [31:0] px, input logic signed [31:0] py,
                                        input logic signed [31:0] pz, output logic [IDX_W-1:0] at);
    if (!find_voxel(px, py, pz, at)) return 1'b0;
    return !vel_loaded[at];
  endfunction

  function automatic logic [63:0] deposit_amount(input logic [15:0] dia);
    logic [63:0] cube, hi, lo;
    cube = 64'(dia) * 64'(dia) * 64'(dia);
    hi = (cube >> 24) * 64'(frac_scale);
    lo = (cube & 64'hFF_FFFF) * 64'(frac_scale);
    return (hi + (lo >> 24)) >> 16;
  endfunction

  function automatic voxel_report_t snapshot(input logic [IDX_W-1:0] at);
    voxel_report_t r;
    r.fraction = frac_mem[at][FRAC_W-1:0];
    r.vel_x = vel_mem_x[at];
    r.vel_y = vel_mem_y[at];
    r.vel_z = vel_mem_z[at];
    r.voxel_at = at;
    r.outside = 1'b0;
    return r;
  endfunction

  function automatic voxel_report_t apply_cmd(input cmd_t op);
    voxel_report_t r;
    logic [IDX_W-1:0] at;
    logic [63:0] add, sum;
    r = '0;
    case (op)
      CMD_CLEAR: begin
        foreach (frac_mem[i]) frac_mem[i] = '0;
      end
      CMD_DEPOSIT: begin
        if (!find_voxel(in_pos_x, in_pos_y, in_pos_z, at)) begin
          r.outside = 1'b1;
        end else begin
          add = deposit_amount(in_diameter);
          sum = 64'(frac_mem[at]) + add;
          if (add > 64'(FRAC_MAX) || sum > 64'(FRAC_MAX)) sum = 64'(FRAC_MAX);
          frac_mem[at] = sum[15:0];
          r = snapshot(at);
        end
      end
      CMD_LOAD: begin
        if (int'(in_load_index) >= RES_X * RES_Y * RES_Z) begin
          r.voxel_at = in_load_index;
          r.outside = 1'b1;
        end else begin
          vel_mem_x[in_load_index] = in_load_vel_x;
          vel_mem_y[in_load_index] = in_load_vel_y;
          vel_mem_z[in_load_index] = in_load_vel_z;
          vel_loaded[in_load_index] = 1'b1;
          r = snapshot(in_load_index);
        end
      end
      default: begin
        if (!find_voxel(in_pos_x, in_pos_y, in_pos_z, at)) r.outside = 1'b1;
        else r = snapshot(at);
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_ORIGIN_X:  return origin[AX_X];
      REG_ORIGIN_Y:  return origin[AX_Y];
      REG_ORIGIN_Z:  return origin[AX_Z];
      REG_INV_LEN_X: return inv_len[AX_X];
      REG_INV_LEN_Y: return inv_len[AX_Y];
      REG_INV_LEN_Z: return inv_len[AX_Z];
      default:       return frac_scale;
    endcase
  endfunction

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    if (fail_count <= 60) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  task automatic compare(input voxel_report_t want);
    if (out_fraction !== want.fraction) flag("fraction", 32'(out_fraction), 32'(want.fraction));
    if (out_vel_x_out !== want.vel_x) flag("vel_x_out", out_vel_x_out, want.vel_x);
    if (out_vel_y_out !== want.vel_y) flag("vel_y_out", out_vel_y_out, want.vel_y);
    if (out_vel_z_out !== want.vel_z) flag("vel_z_out", out_vel_z_out, want.vel_z);
    if (out_voxel_at !== want.voxel_at) flag("voxel_at", 32'(out_voxel_at), 32'(want.voxel_at));
    if (out_outside !== want.outside) flag("outside", 32'(out_outside), 32'(want.outside));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      origin[AX_X] <= '0;
      origin[AX_Y] <= '0;
      origin[AX_Z] <= '0;
      inv_len[AX_X] <= 32'd65536;
      inv_len[AX_Y] <= 32'd65536;
      inv_len[AX_Z] <= 32'd65536;
      frac_scale <= '0;
      foreach (frac_mem[i]) begin
        frac_mem[i] = '0;
        vel_loaded[i] = 1'b0;
      end
      awaited.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[APB_AW-1:2]))
            REG_ORIGIN_X:  origin[AX_X] = pwdata;
            REG_ORIGIN_Y:  origin[AX_Y] = pwdata;
            REG_ORIGIN_Z:  origin[AX_Z] = pwdata;
            REG_INV_LEN_X: inv_len[AX_X] = pwdata;
            REG_INV_LEN_Y: inv_len[AX_Y] = pwdata;
            REG_INV_LEN_Z: inv_len[AX_Z] = pwdata;
            REG_FRAC_SCALE: frac_scale = pwdata;
            default: ;
          endcase
        end else if (prdata !== reg_value(reg_idx_t'(paddr[APB_AW-1:2]))) begin
          flag("register readback", prdata, reg_value(reg_idx_t'(paddr[APB_AW-1:2])));
        end
      end
      if (out_valid) begin
        if (awaited.size() == 0) flag("result with nothing awaited", 32'(out_voxel_at), '0);
        else compare(awaited.pop_front());
      end
      if (start && !busy) awaited.push_back(apply_cmd(cmd_t'(in_cmd)));
    end
    pending <= awaited.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the voxel solid-fraction binner testbench: clock, reset, register setup,
// command stimulus and verdict. Depends on vsfb_pkg, vsfb_checker and the binner RTL.
module tb_top;
  import vsfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 300;

  typedef struct {
    cmd_t               cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        dia;
    logic [IDX_W-1:0]   lidx;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } voxel_cmd_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_cmd;
  logic signed [31:0]   in_pos_x;
  logic signed [31:0]   in_pos_y;
  logic signed [31:0]   in_pos_z;
  logic [15:0]          in_diameter;
  logic [IDX_W-1:0]     in_load_index;
  logic signed [31:0]   in_load_vel_x;
  logic signed [31:0]   in_load_vel_y;
  logic signed [31:0]   in_load_vel_z;
  logic                 out_valid;
  logic [FRAC_W-1:0]    out_fraction;
  logic signed [31:0]   out_vel_x_out;
  logic signed [31:0]   out_vel_y_out;
  logic signed [31:0]   out_vel_z_out;
  logic [IDX_W-1:0]     out_voxel_at;
  logic                 out_outside;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [APB_AW-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  int                   mismatches;
  int                   pending_results;

  int                   cycles = 0;
  bit                   calm = 1'b0;
  int                   clears_left = 5;
  logic signed [31:0]   grid_org [3];
  logic [31:0]          grid_inv [3];
  logic [31:0]          grid_scale;
  logic signed [31:0]   last_pos [3] = '{default: '0};

  voxel_solid_fraction_binner dut (.*);

  vsfb_checker chk (.*, .fail_count(mismatches), .pending(pending_results));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic voxel_cmd_t mk(input cmd_t op, input logic [31:0] px, input logic [31:0] py,
                                    input logic [31:0] pz, input logic [15:0] dia,
                                    input logic [IDX_W-1:0] lidx, input logic [31:0] vx,
                                    input logic [31:0] vy, input logic [31:0] vz);
    voxel_cmd_t it;
    it.cmd = op;
    it.px = px;
    it.py = py;
    it.pz = pz;
    it.dia = dia;
    it.lidx = lidx;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    return it;
  endfunction

  // Mostly land inside the grid under the current setup, sometimes on its edges.
  function automatic logic signed [31:0] pick_pos(input axis_t ax, input int res);
    logic [63:0] span;
    logic [31:0] off;
    int roll;
    span = (grid_inv[ax] == 0) ? 64'hFFFF_FFFF : (64'(res) << 32) / 64'(grid_inv[ax]);
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    if (span == 0) span = 1;
    roll = $urandom_range(99);
    if (roll < 75) begin
      off = $urandom_range(32'(span - 1), 0);
    end else if (roll < 88) begin
      case ($urandom_range(3))
        0: off = 32'(span - 1);
        1: off = 32'(span);
        2: off = 32'hFFFF_FFFF;
        default: off = '0;
      endcase
    end else begin
      return $urandom();
    end
    return grid_org[ax] + off;
  endfunction

  task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input reg_idx_t r);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_grid(input int ph);
    reg_idx_t r;
    case (ph)
      0: begin
        grid_org = '{default: '0};
        grid_inv = '{default: 32'd65536};
        grid_scale = 32'h0CCD_0000;
      end
      1: begin
        foreach (grid_org[i]) begin
          grid_org[i] = $urandom_range(32'h0080_0000) - 32'h0040_0000;
          grid_inv[i] = $urandom_range(32'h0004_0000, 32'h0000_4000);
        end
        grid_scale = $urandom_range(32'h2000_0000, 32'h0100_0000);
      end
      2: begin
        grid_org[AX_X] = 32'h8000_0000;
        grid_org[AX_Y] = 32'h7FFF_FFFF;
        grid_org[AX_Z] = '0;
        grid_inv[AX_X] = 32'hFFFF_FFFF;
        grid_inv[AX_Y] = '0;
        grid_inv[AX_Z] = 32'd1;
        grid_scale = 32'hFFFF_FFFF;
      end
      3: begin
        foreach (grid_org[i]) begin
          grid_org[i] = $urandom_range(32'h0200_0000) - 32'h0100_0000;
          grid_inv[i] = 32'h0002_0000;
        end
        grid_scale = '0;
      end
      default: begin
        foreach (grid_org[i]) begin
          grid_org[i] = $urandom();
          grid_inv[i] = $urandom();
        end
        grid_scale = $urandom();
      end
    endcase
    reg_write(REG_ORIGIN_X, grid_org[AX_X]);
    reg_write(REG_ORIGIN_Y, grid_org[AX_Y]);
    reg_write(REG_ORIGIN_Z, grid_org[AX_Z]);
    reg_write(REG_INV_LEN_X, grid_inv[AX_X]);
    reg_write(REG_INV_LEN_Y, grid_inv[AX_Y]);
    reg_write(REG_INV_LEN_Z, grid_inv[AX_Z]);
    reg_write(REG_FRAC_SCALE, grid_scale);
    r = r.first();
    do begin
      reg_read(r);
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic send(input voxel_cmd_t it);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if (!calm && $urandom_range(99) < 20) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_cmd <= it.cmd;
        in_pos_x <= it.px;
        in_pos_y <= it.py;
        in_pos_z <= it.pz;
        in_diameter <= it.dia;
        in_load_index <= it.lidx;
        in_load_vel_x <= it.vx;
        in_load_vel_y <= it.vy;
        in_load_vel_z <= it.vz;
        @(posedge clk);
        taken = !busy;
      end
    end
  endtask

  // Load the target voxel's velocity first when a deposit or query would read it unset.
  task automatic issue(input voxel_cmd_t it);
    voxel_cmd_t fill;
    logic [IDX_W-1:0] at;
    @(negedge clk);
    start <= 1'b0;
    if ((it.cmd == CMD_DEPOSIT || it.cmd == CMD_QUERY) &&
        chk.needs_velocity(it.px, it.py, it.pz, at)) begin
      fill = it;
      fill.cmd = CMD_LOAD;
      fill.lidx = at;
      fill.vx = $urandom();
      fill.vy = $urandom();
      fill.vz = $urandom();
      send(fill);
    end
    send(it);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0 || busy) @(negedge clk);
  endtask

  task automatic make_random(output voxel_cmd_t it);
    int roll;
    roll = $urandom_range(999);
    if (roll < 3 && clears_left > 0) begin
      it.cmd = CMD_CLEAR;
      clears_left--;
    end else if (roll < 420) begin
      it.cmd = CMD_DEPOSIT;
    end else if (roll < 640) begin
      it.cmd = CMD_LOAD;
    end else begin
      it.cmd = CMD_QUERY;
    end
    if ($urandom_range(99) >= 30) begin
      last_pos[AX_X] = pick_pos(AX_X, RES_X_DEF);
      last_pos[AX_Y] = pick_pos(AX_Y, RES_Y_DEF);
      last_pos[AX_Z] = pick_pos(AX_Z, RES_Z_DEF);
    end
    it.px = last_pos[AX_X];
    it.py = last_pos[AX_Y];
    it.pz = last_pos[AX_Z];
    roll = $urandom_range(99);
    if (roll < 50) it.dia = $urandom_range(16'h0300);
    else if (roll < 80) it.dia = $urandom();
    else if (roll < 90) it.dia = '0;
    else it.dia = 16'hFFFF;
    it.lidx = $urandom();
    it.vx = $urandom();
    it.vy = $urandom();
    it.vz = $urandom();
  endtask

  initial begin
    voxel_cmd_t it;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_CLEAR;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_diameter = '0;
    in_load_index = '0;
    in_load_vel_x = '0;
    in_load_vel_y = '0;
    in_load_vel_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      program_grid(ph);
      if (ph == 0) begin
        issue(mk(CMD_LOAD, 0, 0, 0, 0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        issue(mk(CMD_LOAD, '1, '1, '1, 16'hFFFF, '1, '1, '1, '1));
        issue(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 0, 0, 0, 16'h0100, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 0, 0, 0, 16'h0000, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 32'h0001_0000, 0, 0, 16'h01C0, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 32'h0001_0000, 0, 0, 16'h01C0, 0, 0, 0, 0));
        issue(mk(CMD_QUERY, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 0, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 16'h0100,
                 0, 0, 0, 0));
        issue(mk(CMD_QUERY, 32'h0020_0000, 0, 0, 0, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 0, 32'hFFFF_FFFF, 0, 16'h0100, 0, 0, 0, 0));
        issue(mk(CMD_QUERY, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        issue(mk(CMD_QUERY, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0));
        issue(mk(CMD_CLEAR, '1, '1, '1, 16'hFFFF, '1, '1, '1, '1));
        issue(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0));
        issue(mk(CMD_DEPOSIT, 32'h0001_0000, 0, 0, 16'h0100, 0, 0, 0, 0));
        issue(mk(CMD_LOAD, 0, 0, 0, 0, 15'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678));
        issue(mk(CMD_LOAD, 0, 0, 0, 0, 15'h2AAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000));
        issue(mk(CMD_QUERY, 32'h0015_8000, 32'h000A_4000, 32'h0015_0001, 0, 0, 0, 0, 0));
      end
      calm = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PHASES - 1 && n == PHASE_ITEMS / 2) settle();
        make_random(it);
        issue(it);
      end
    end

    settle();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
